/* hw/rtl/ppnt_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure pad note trigger package
// Shared types, register indexes, event codes and the sequencer microcode.
// ----------------------------------------------------------------------------
package ppnt_pkg;

  localparam int NUM_SENSORS = 64;

  localparam logic [1:0] CFG_FLOOR   = 2'd0;
  localparam logic [1:0] CFG_CEILING = 2'd1;
  localparam logic [1:0] CFG_CHANNEL = 2'd2;

  localparam logic [1:0] EV_NONE     = 2'd0;
  localparam logic [1:0] EV_NOTE_ON  = 2'd1;
  localparam logic [1:0] EV_NOTE_OFF = 2'd2;

  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_LOAD = 2'd1;
  localparam logic [1:0] STEP_DIV  = 2'd2;
  localparam logic [1:0] STEP_EMIT = 2'd3;

  localparam logic [1:0] COND_NEVER    = 2'd0;
  localparam logic [1:0] COND_NO_REQ   = 2'd1;
  localparam logic [1:0] COND_K_NZ     = 2'd2;
  localparam logic [1:0] COND_OUT_BUSY = 2'd3;

  typedef struct packed {
    logic [5:0] sensor_id;
    logic [9:0] pressure;
    logic [6:0] note_number;
  } ppnt_in_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [6:0] event_note;
    logic [6:0] event_velocity;
    logic [3:0] event_channel;
    logic [5:0] event_sensor;
  } ppnt_out_t;

  typedef struct packed {
    logic [9:0] pressure_floor;
    logic [9:0] pressure_ceiling;
    logic [3:0] midi_channel;
  } ppnt_cfg_t;

  typedef struct packed {
    logic       accept;
    logic       load;
    logic       div;
    logic       emit;
    logic [1:0] cond;
    logic [1:0] target;
  } ucode_t;

  typedef struct packed {
    logic in_pending;
    logic k_nz;
    logic out_busy;
  } ppnt_status_t;

  function automatic ucode_t ucode_rom(input logic [1:0] step);
    ucode_t w;
    w = '0;
    unique case (step)
      STEP_IDLE: begin
        w.accept = 1'b1;
        w.cond   = COND_NO_REQ;
        w.target = STEP_IDLE;
      end
      STEP_LOAD: begin
        w.load   = 1'b1;
        w.cond   = COND_NEVER;
        w.target = STEP_IDLE;
      end
      STEP_DIV: begin
        w.div    = 1'b1;
        w.cond   = COND_K_NZ;
        w.target = STEP_DIV;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_EMIT;
      end
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/ppnt_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure pad note trigger sequencer
// Step counter over the microcode table with conditional jumps.
// ----------------------------------------------------------------------------
module ppnt_sequencer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ppnt_pkg::ppnt_status_t status,
  output ppnt_pkg::ucode_t           ctl
);

  logic [1:0] step;
  logic [1:0] step_next;
  logic       take_jump;

  assign ctl = ppnt_pkg::ucode_rom(step);

  always_comb begin
    unique case (ctl.cond)
      ppnt_pkg::COND_NEVER:    take_jump = 1'b0;
      ppnt_pkg::COND_NO_REQ:   take_jump = !status.in_pending;
      ppnt_pkg::COND_K_NZ:     take_jump = status.k_nz;
      ppnt_pkg::COND_OUT_BUSY: take_jump = status.out_busy;
      default:                 take_jump = 1'b0;
    endcase
    step_next = take_jump ? ctl.target : step + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ppnt_pkg::STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/ppnt_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure pad note trigger datapath
// Clamp and scale, shift-subtract divider, pressed bitmap and result register.
// ----------------------------------------------------------------------------
module ppnt_datapath (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire ppnt_pkg::ucode_t      ctl,
  input  wire ppnt_pkg::ppnt_cfg_t   cfg,
  input  wire logic                  in_valid,
  input  wire ppnt_pkg::ppnt_in_t    in_data,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output ppnt_pkg::ppnt_out_t        out_data,
  output ppnt_pkg::ppnt_status_t     status
);

  ppnt_pkg::ppnt_in_t in_reg;
  logic [ppnt_pkg::NUM_SENSORS-1:0] pressed_map;
  logic        zero_span;
  logic [16:0] num;
  logic [9:0]  den;
  logic [6:0]  quot;
  logic [2:0]  k;

  logic [9:0]  p_clamped;
  logic [9:0]  diff;
  logic [16:0] trial;
  logic        fits;
  logic [6:0]  vel;
  logic        in_range;
  logic        pressed;
  logic [1:0]  kind;
  logic        out_free;
  logic        do_emit;
  ppnt_pkg::ppnt_out_t result;

  always_comb begin
    if (in_reg.pressure < cfg.pressure_floor) begin
      p_clamped = cfg.pressure_floor;
    end else if (in_reg.pressure > cfg.pressure_ceiling) begin
      p_clamped = cfg.pressure_ceiling;
    end else begin
      p_clamped = in_reg.pressure;
    end
    diff  = p_clamped - cfg.pressure_floor;
    trial = 17'(den) << k;
    fits  = num >= trial;
  end

  always_comb begin
    vel      = zero_span ? 7'd0 : quot;
    in_range = int'(in_reg.sensor_id) < ppnt_pkg::NUM_SENSORS;
    pressed  = pressed_map[in_reg.sensor_id];
    kind     = ppnt_pkg::EV_NONE;
    if (in_range && (vel != 7'd0) && !pressed) begin
      kind = ppnt_pkg::EV_NOTE_ON;
    end else if (in_range && (vel == 7'd0) && pressed) begin
      kind = ppnt_pkg::EV_NOTE_OFF;
    end
    result = '0;
    if (kind != ppnt_pkg::EV_NONE) begin
      result.event_kind     = kind;
      result.event_note     = in_reg.note_number;
      result.event_velocity = (kind == ppnt_pkg::EV_NOTE_ON) ? vel : 7'd0;
      result.event_channel  = cfg.midi_channel;
      result.event_sensor   = in_reg.sensor_id;
    end
  end

  assign out_free          = !out_valid || out_ready;
  assign do_emit           = ctl.emit && out_free;
  assign status.in_pending = in_valid;
  assign status.k_nz       = k != 3'd0;
  assign status.out_busy   = !out_free;

  always_ff @(posedge clk) begin
    if (ctl.accept && in_valid) begin
      in_reg <= in_data;
    end
    if (ctl.load) begin
      zero_span <= !(cfg.pressure_ceiling > cfg.pressure_floor);
      num       <= {diff, 7'd0} - {7'd0, diff};
      den       <= cfg.pressure_ceiling - cfg.pressure_floor;
      quot      <= '0;
      k         <= 3'd6;
    end
    if (ctl.div) begin
      if (fits) begin
        num     <= num - trial;
        quot[k] <= 1'b1;
      end
      if (k != 3'd0) begin
        k <= k - 3'd1;
      end
    end
    if (do_emit) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pressed_map <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (do_emit) begin
        if (kind == ppnt_pkg::EV_NOTE_ON) begin
          pressed_map[in_reg.sensor_id] <= 1'b1;
        end else if (kind == ppnt_pkg::EV_NOTE_OFF) begin
          pressed_map[in_reg.sensor_id] <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_on_sets_map : assert property (@(posedge clk) disable iff (rst)
    (do_emit && kind == ppnt_pkg::EV_NOTE_ON) |=> pressed_map[in_reg.sensor_id])
    else $error("Note-on did not mark the sensor as pressed.");

  a_off_clears_map : assert property (@(posedge clk) disable iff (rst)
    (do_emit && kind == ppnt_pkg::EV_NOTE_OFF) |=> !pressed_map[in_reg.sensor_id])
    else $error("Note-off did not release the sensor.");

  a_none_is_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_kind == ppnt_pkg::EV_NONE) |->
      (out_data.event_note == 7'd0 && out_data.event_velocity == 7'd0 &&
       out_data.event_channel == 4'd0 && out_data.event_sensor == 6'd0))
    else $error("No-event result carries nonzero fields.");

  a_off_no_velocity : assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.event_kind == ppnt_pkg::EV_NOTE_OFF) |->
      out_data.event_velocity == 7'd0)
    else $error("Note-off result carries a velocity.");

endmodule
`default_nettype wire

/* hw/rtl/pressure_pad_note_trigger.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pressure pad note trigger
// Turns force-sensor samples into note-on and note-off events.
// ----------------------------------------------------------------------------
// A sample is taken in the idle step; the load step, the seven-step
// shift-subtract divide loop and the emit step follow, and emit waits while
// the result register is full; no new sample is taken before the idle step.
// Reset clears the pressed bitmap and the result register's valid flag, and
// loads floor 0, ceiling 1023 and channel 0.
module pressure_pad_note_trigger (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire ppnt_pkg::ppnt_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output ppnt_pkg::ppnt_out_t      out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [9:0]          cfg_data
);

  ppnt_pkg::ppnt_cfg_t    cfg;
  ppnt_pkg::ucode_t       ctl;
  ppnt_pkg::ppnt_status_t status;

  assign cfg_ready = !rst;
  assign in_ready  = ctl.accept && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressure_floor   <= 10'd0;
      cfg.pressure_ceiling <= 10'd1023;
      cfg.midi_channel     <= 4'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ppnt_pkg::CFG_FLOOR:   cfg.pressure_floor   <= cfg_data;
        ppnt_pkg::CFG_CEILING: cfg.pressure_ceiling <= cfg_data;
        ppnt_pkg::CFG_CHANNEL: cfg.midi_channel     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  ppnt_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctl    (ctl)
  );

  ppnt_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (status)
  );

endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pressure pad note trigger testbench
// Drives force-sensor samples and register writes into the block, predicts
// the note event for every accepted sample from its own copy of the pressed
// bitmap and settings, and checks each event field by field in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ppnt_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;

  class ppnt_scoreboard;
    logic [9:0]  floor_q;
    logic [9:0]  ceil_q;
    logic [3:0]  channel_q;
    bit          pressed[NUM_SENSORS];
    ppnt_out_t   events_due[$];
    int unsigned errors;

    function new();
      floor_q   = 10'd0;
      ceil_q    = 10'd1023;
      channel_q = 4'd0;
      foreach (pressed[i]) pressed[i] = 1'b0;
      errors    = 0;
    endfunction

    function void apply_register(logic [1:0] idx, logic [9:0] data);
      case (idx)
        CFG_FLOOR:   floor_q   = data;
        CFG_CEILING: ceil_q    = data;
        CFG_CHANNEL: channel_q = data[3:0];
        default: ;
      endcase
    endfunction

    function logic [6:0] velocity_of(logic [9:0] p);
      int unsigned offset;
      int unsigned span;
      logic [9:0]  c;
      if (ceil_q <= floor_q) return 7'd0;
      c = p;
      if (c < floor_q) c = floor_q;
      if (c > ceil_q) c = ceil_q;
      offset = c - floor_q;
      span   = ceil_q - floor_q;
      return 7'((offset * 127) / span);
    endfunction

    function void note_request(ppnt_in_t s);
      ppnt_out_t  e;
      logic [6:0] vel;
      e   = '0;
      vel = velocity_of(s.pressure);
      if (vel != 7'd0 && !pressed[s.sensor_id]) begin
        pressed[s.sensor_id] = 1'b1;
        e.event_kind         = EV_NOTE_ON;
        e.event_velocity     = vel;
      end else if (vel == 7'd0 && pressed[s.sensor_id]) begin
        pressed[s.sensor_id] = 1'b0;
        e.event_kind         = EV_NOTE_OFF;
      end
      if (e.event_kind != EV_NONE) begin
        e.event_note    = s.note_number;
        e.event_channel = channel_q;
        e.event_sensor  = s.sensor_id;
      end
      events_due.push_back(e);
    endfunction

    function int pending();
      return events_due.size();
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $time, what);
      errors++;
    endtask

    task compare_field(string name, int got, int want);
      if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    task check_result(ppnt_out_t got);
      ppnt_out_t e;
      if (events_due.size() == 0) begin
        report($sformatf("event %h with no request pending", got));
        return;
      end
      e = events_due.pop_front();
      compare_field("event_kind", got.event_kind, e.event_kind);
      compare_field("event_note", got.event_note, e.event_note);
      compare_field("event_velocity", got.event_velocity, e.event_velocity);
      compare_field("event_channel", got.event_channel, e.event_channel);
      compare_field("event_sensor", got.event_sensor, e.event_sensor);
    endtask
  endclass

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  ppnt_in_t   in_data;
  logic       out_valid;
  logic       out_ready;
  ppnt_out_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [9:0] cfg_data;

  ppnt_scoreboard sb = new();

  bit         tx_idle_en;
  bit         rx_idle_en;
  bit         hold_off_req;
  int         hold_left;
  int         stall_left;
  logic [6:0] note_of[NUM_SENSORS];

  pressure_pad_note_trigger dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    out_ready  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_left    = 400;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
      end
    end
  end

  task send_sample(logic [5:0] sid, logic [9:0] p, logic [6:0] nn);
    ppnt_in_t s;
    int       gap;
    s.sensor_id   = sid;
    s.pressure    = p;
    s.note_number = nn;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(s);
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task write_register(logic [1:0] idx, logic [9:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task write_settings(logic [9:0] lo, logic [9:0] hi, logic [9:0] chan_word);
    drain_results();
    write_register(CFG_FLOOR, lo);
    write_register(CFG_CEILING, hi);
    write_register(CFG_CHANNEL, chan_word);
    if ($urandom_range(0, 1) == 0) write_register(CFG_UNUSED, 10'($urandom_range(0, 1023)));
  endtask

  function automatic logic [9:0] pick_pressure(logic [9:0] lo, logic [9:0] hi);
    case ($urandom_range(0, 9))
      0, 1, 2: return 10'($urandom_range(0, lo));
      3, 4, 5: return 10'($urandom_range(lo, hi));
      6, 7:    return 10'($urandom_range(hi, 1023));
      default: return 10'($urandom_range(0, 1023));
    endcase
  endfunction

  task run_phase(int unsigned n_items, logic [9:0] lo, logic [9:0] hi, bit hold);
    int unsigned sent;
    int unsigned burst;
    logic [5:0]  pool[4];
    logic [5:0]  sid;
    logic [6:0]  nn;
    write_settings(lo, hi, 10'($urandom_range(0, 1023)));
    if (hold) hold_off_req = 1'b1;
    foreach (pool[i]) pool[i] = 6'($urandom_range(0, 63));
    sent = 0;
    while (sent < n_items) begin
      sid   = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : pool[$urandom_range(0, 3)];
      burst = $urandom_range(1, 6);
      repeat (burst) begin
        nn = ($urandom_range(0, 6) == 0) ? 7'($urandom_range(0, 127)) : note_of[sid];
        send_sample(sid, pick_pressure(lo, hi), nn);
        sent++;
      end
    end
  endtask

  initial begin
    logic [9:0] lo;
    logic [9:0] hi;
    rst          = 1'b1;
    in_valid     = 1'b0;
    in_data      = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    tx_idle_en   = 1'b1;
    rx_idle_en   = 1'b1;
    hold_off_req = 1'b0;
    foreach (note_of[i]) note_of[i] = 7'($urandom_range(0, 127));
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Settings from reset: full range, channel zero.
    send_sample(6'd0, 10'd0, 7'd0);
    send_sample(6'd0, 10'd1023, 7'd127);
    send_sample(6'd0, 10'd1023, 7'd127);
    send_sample(6'd0, 10'd0, 7'd127);
    send_sample(6'd63, 10'd8, 7'd0);
    send_sample(6'd63, 10'd9, 7'd64);
    send_sample(6'd63, 10'd1023, 7'd64);
    send_sample(6'd63, 10'd5, 7'd64);
    send_sample(6'd42, 10'd512, 7'd85);

    drain_results();
    write_register(CFG_UNUSED, 10'h3FF);
    write_settings(10'd100, 10'd900, 10'h3FF);
    send_sample(6'd42, 10'd100, 7'd85);
    send_sample(6'd21, 10'd99, 7'd21);
    send_sample(6'd21, 10'd101, 7'd21);
    send_sample(6'd21, 10'd900, 7'd21);
    send_sample(6'd21, 10'd1023, 7'd21);

    // A ceiling that is not above the floor forces a zero velocity.
    write_settings(10'd500, 10'd500, 10'h3FA);
    send_sample(6'd21, 10'd1023, 7'd21);
    send_sample(6'd7, 10'd1023, 7'd7);
    write_settings(10'd1023, 10'd0, 10'h000);
    send_sample(6'd7, 10'd0, 7'd7);
    send_sample(6'd7, 10'd1023, 7'd7);

    write_settings(10'd1022, 10'd1023, 10'd5);
    send_sample(6'd7, 10'd1023, 7'd7);
    send_sample(6'd7, 10'd1022, 7'd7);
    write_settings(10'd0, 10'd1, 10'd15);
    send_sample(6'd8, 10'd1, 7'd127);
    send_sample(6'd8, 10'd0, 7'd127);
    send_sample(6'd8, 10'd1023, 7'd0);

    run_phase(110, 10'd0, 10'd1023, 1'b0);
    run_phase(110, 10'd0, 10'd1, 1'b0);
    run_phase(110, 10'd1022, 10'd1023, 1'b0);
    lo = 10'($urandom_range(0, 1000));
    hi = 10'($urandom_range(lo + 1, 1023));
    run_phase(110, lo, hi, 1'b1);
    run_phase(40, 10'd1023, 10'd0, 1'b0);
    lo = 10'($urandom_range(0, 1000));
    hi = 10'($urandom_range(lo + 1, 1023));
    run_phase(110, lo, hi, 1'b0);
    run_phase(110, 10'd0, 10'd1023, 1'b0);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    lo = 10'($urandom_range(0, 600));
    hi = 10'($urandom_range(lo + 1, 1023));
    run_phase(200, lo, hi, 1'b0);

    drain_results();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
